[rtl/whhs_pkg.sv]
// ----------------------------------------------------------------------------
// whhs_pkg
// Types and constants shared by the weighted heavy-hitter sketch modules.
// ----------------------------------------------------------------------------
`default_nettype none

package whhs_pkg;

  localparam int MAX_SLOTS = 64;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int KEY_W     = 32;
  localparam int WGT_W     = 31;
  localparam int CNT_W     = 64;
  localparam int OCC_W     = 7;

  localparam logic [CNT_W-1:0]  ALL_ONES   = {CNT_W{1'b1}};
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(MAX_SLOTS - 1);
  localparam logic [OCC_W-1:0]  SLOTS_RST  = OCC_W'(MAX_SLOTS);

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LK_RD,
    ST_LK_EX,
    ST_PLACE,
    ST_PL_MIN,
    ST_PEND_ADD,
    ST_PEND_CMP,
    ST_LW_RD,
    ST_LW_EX,
    ST_LW_MIN,
    ST_LW_END,
    ST_DONE
  } state_t;

  // Commands from the sequencer to the entry table.
  typedef struct packed {
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] wr_addr;
    logic              key_we;
    logic              cnt_we;
    logic [KEY_W-1:0]  key_wd;
    logic [CNT_W-1:0]  cnt_wd;
    logic              set_valid;
    logic              clr_valid;
    logic              clr_all;
  } tbl_ctrl_t;

  // Registered read data and the valid bit of the addressed entry.
  typedef struct packed {
    logic [KEY_W-1:0] rd_key;
    logic [CNT_W-1:0] rd_count;
    logic             valid_bit;
  } tbl_stat_t;

  // One finished result.
  typedef struct packed {
    logic [CNT_W-1:0] pending;
    logic [CNT_W-1:0] min_bound;
    logic [OCC_W-1:0] occupancy;
    logic [CNT_W-1:0] key_count;
  } result_t;

endpackage

`default_nettype wire

[rtl/whhs_alu.sv]
// ----------------------------------------------------------------------------
// whhs_alu
// Shared 64-bit add/subtract unit; it reports a zero result, and borrow on subtraction.
// ----------------------------------------------------------------------------
`default_nettype none

module whhs_alu
  import whhs_pkg::*;
(
  input  alu_op_t          op,
  input  logic [CNT_W-1:0] a,
  input  logic [CNT_W-1:0] b,
  output logic [CNT_W-1:0] res,
  output logic             borrow,
  output logic             zero
);

  logic [CNT_W:0] sum;

  always_comb begin
    unique case (op)
      ALU_ADD: sum = {1'b0, a} + {1'b0, b};
      ALU_SUB: sum = {1'b0, a} - {1'b0, b};
      default: sum = '0;
    endcase
  end

  assign res    = sum[CNT_W-1:0];
  // For a subtraction the top bit is set exactly when a < b.
  assign borrow = (op == ALU_SUB) && sum[CNT_W];
  assign zero   = (sum[CNT_W-1:0] == '0);

endmodule

`default_nettype wire

[rtl/whhs_table.sv]
// ----------------------------------------------------------------------------
// whhs_table
// Key and count memories with registered reads, plus per-entry valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module whhs_table
  import whhs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  tbl_ctrl_t ctl,
  output tbl_stat_t stat
);

  logic [KEY_W-1:0]     keys   [MAX_SLOTS];
  logic [CNT_W-1:0]     counts [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] valid;
  logic [KEY_W-1:0]     rd_key;
  logic [CNT_W-1:0]     rd_count;

  always_ff @(posedge clk) begin
    if (ctl.key_we) begin
      keys[ctl.wr_addr] <= ctl.key_wd;
    end
    rd_key <= keys[ctl.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.cnt_we) begin
      counts[ctl.wr_addr] <= ctl.cnt_wd;
    end
    rd_count <= counts[ctl.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr_all) begin
      valid <= '0;
    end else if (ctl.set_valid) begin
      valid[ctl.wr_addr] <= 1'b1;
    end else if (ctl.clr_valid) begin
      valid[ctl.wr_addr] <= 1'b0;
    end
  end

  assign stat.rd_key    = rd_key;
  assign stat.rd_count  = rd_count;
  assign stat.valid_bit = valid[ctl.rd_addr];

endmodule

`default_nettype wire

[rtl/whhs_ctrl.sv]
// ----------------------------------------------------------------------------
// whhs_ctrl
// Sequencer: lookup scan, insertion, pending accumulation and lowering passes.
// ----------------------------------------------------------------------------
`default_nettype none

module whhs_ctrl
  import whhs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [OCC_W-1:0] lim,
  input  logic             in_valid,
  output logic             in_ready,
  input  opcode_t          in_op,
  input  logic [KEY_W-1:0] in_key,
  input  logic [WGT_W-1:0] in_weight,
  output logic             res_valid,
  input  logic             out_free,
  output result_t          res,
  output tbl_ctrl_t        tc,
  input  tbl_stat_t        ts
);

  state_t            state, state_next;
  logic [SLOT_W-1:0] idx, idx_next;
  logic [SLOT_W-1:0] free_idx, free_idx_next;
  logic              free_found, free_found_next;
  logic              pass2, pass2_next;
  logic              from_pend, from_pend_next;
  logic [KEY_W-1:0]  key_r, key_r_next;
  logic [WGT_W-1:0]  wgt, wgt_next;
  logic [CNT_W-1:0]  kc, kc_next;
  logic [CNT_W-1:0]  lazy_min, lazy_min_next;
  logic [CNT_W-1:0]  pending, pending_next;
  logic [OCC_W-1:0]  occ, occ_next;
  logic [CNT_W-1:0]  amt, amt_next;
  logic [CNT_W-1:0]  lo, lo_next;
  logic [CNT_W-1:0]  surv, surv_next;
  logic [CNT_W-1:0]  place_val, place_val_next;

  alu_op_t          alu_op;
  logic [CNT_W-1:0] alu_a, alu_b, alu_res;
  logic             alu_borrow, alu_zero;
  logic [CNT_W-1:0] wgt_ext;
  logic [CNT_W-1:0] lo_new;

  assign wgt_ext = {{(CNT_W-WGT_W){1'b0}}, wgt};

  whhs_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .borrow (alu_borrow),
    .zero   (alu_zero)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      lazy_min <= ALL_ONES;
      pending  <= '0;
      occ      <= '0;
    end else begin
      state    <= state_next;
      lazy_min <= lazy_min_next;
      pending  <= pending_next;
      occ      <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    free_idx   <= free_idx_next;
    free_found <= free_found_next;
    pass2      <= pass2_next;
    from_pend  <= from_pend_next;
    key_r      <= key_r_next;
    wgt        <= wgt_next;
    kc         <= kc_next;
    amt        <= amt_next;
    lo         <= lo_next;
    surv       <= surv_next;
    place_val  <= place_val_next;
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    free_idx_next   = free_idx;
    free_found_next = free_found;
    pass2_next      = pass2;
    from_pend_next  = from_pend;
    key_r_next      = key_r;
    wgt_next        = wgt;
    kc_next         = kc;
    lazy_min_next   = lazy_min;
    pending_next    = pending;
    occ_next        = occ;
    amt_next        = amt;
    lo_next         = lo;
    surv_next       = surv;
    place_val_next  = place_val;
    lo_new          = lo;
    tc              = '0;
    tc.rd_addr      = idx;
    tc.wr_addr      = idx;
    alu_op          = ALU_SUB;
    alu_a           = '0;
    alu_b           = '0;
    in_ready        = 1'b0;
    res_valid       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_CLEAR) begin
            tc.clr_all    = 1'b1;
            occ_next      = '0;
            lazy_min_next = ALL_ONES;
            pending_next  = '0;
            kc_next       = '0;
            state_next    = ST_DONE;
          end else begin
            key_r_next      = in_key;
            wgt_next        = in_weight;
            idx_next        = '0;
            free_found_next = 1'b0;
            pass2_next      = 1'b0;
            state_next      = ST_LK_RD;
          end
        end
      end

      ST_LK_RD: state_next = ST_LK_EX;

      ST_LK_EX: begin
        alu_op = ALU_ADD;
        alu_a  = ts.rd_count;
        alu_b  = wgt_ext;
        if (ts.valid_bit && (ts.rd_key == key_r)) begin
          tc.cnt_we  = 1'b1;
          tc.cnt_wd  = alu_res;
          kc_next    = alu_res;
          state_next = ST_DONE;
        end else begin
          if (!ts.valid_bit && !free_found) begin
            free_idx_next   = idx;
            free_found_next = 1'b1;
          end
          if (idx == LAST_SLOT) begin
            if (occ < lim) begin
              place_val_next = wgt_ext;
              from_pend_next = 1'b0;
              state_next     = ST_PLACE;
            end else begin
              state_next = ST_PEND_ADD;
            end
          end else begin
            idx_next   = idx + 1'b1;
            state_next = ST_LK_RD;
          end
        end
      end

      ST_PLACE: begin
        tc.wr_addr   = free_idx;
        tc.key_we    = 1'b1;
        tc.cnt_we    = 1'b1;
        tc.key_wd    = key_r;
        tc.cnt_wd    = place_val;
        tc.set_valid = 1'b1;
        occ_next     = occ + 1'b1;
        kc_next      = place_val;
        if (from_pend) begin
          pending_next = '0;
        end
        state_next = ST_PL_MIN;
      end

      ST_PL_MIN: begin
        alu_a = place_val;
        alu_b = lazy_min;
        if (alu_borrow) begin
          lazy_min_next = place_val;
        end
        state_next = ST_DONE;
      end

      ST_PEND_ADD: begin
        alu_op       = ALU_ADD;
        alu_a        = pending;
        alu_b        = wgt_ext;
        pending_next = alu_res;
        state_next   = ST_PEND_CMP;
      end

      // Pending against the bound; when it reaches it, take the bound off
      // and start a lowering pass by that amount.
      ST_PEND_CMP: begin
        alu_a = pending;
        alu_b = lazy_min;
        if (alu_borrow) begin
          kc_next    = '0;
          state_next = ST_DONE;
        end else begin
          pending_next    = alu_res;
          amt_next        = lazy_min;
          lo_next         = ALL_ONES;
          idx_next        = '0;
          free_found_next = 1'b0;
          state_next      = ST_LW_RD;
        end
      end

      ST_LW_RD: state_next = ST_LW_EX;

      ST_LW_EX: begin
        alu_a = ts.rd_count;
        alu_b = amt;
        if (ts.valid_bit && !(alu_borrow || alu_zero)) begin
          tc.cnt_we  = 1'b1;
          tc.cnt_wd  = alu_res;
          surv_next  = alu_res;
          state_next = ST_LW_MIN;
        end else begin
          if (ts.valid_bit) begin
            tc.clr_valid = 1'b1;
            occ_next     = occ - 1'b1;
          end
          if (!free_found) begin
            free_idx_next   = idx;
            free_found_next = 1'b1;
          end
          if (idx == LAST_SLOT) begin
            lazy_min_next = lo;
            state_next    = ST_LW_END;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = ST_LW_RD;
          end
        end
      end

      ST_LW_MIN: begin
        alu_a   = surv;
        alu_b   = lo;
        lo_new  = alu_borrow ? surv : lo;
        lo_next = lo_new;
        if (idx == LAST_SLOT) begin
          lazy_min_next = lo_new;
          state_next    = ST_LW_END;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_LW_RD;
        end
      end

      ST_LW_END: begin
        if (pending == '0) begin
          kc_next    = '0;
          state_next = ST_DONE;
        end else if (occ < lim) begin
          place_val_next = pending;
          from_pend_next = 1'b1;
          state_next     = ST_PLACE;
        end else if (!pass2) begin
          pass2_next = 1'b1;
          state_next = ST_PEND_CMP;
        end else begin
          kc_next    = '0;
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  assign res.key_count = kc;
  assign res.occupancy = occ;
  assign res.min_bound = lazy_min;
  assign res.pending   = pending;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(MAX_SLOTS))
    else $error("occupancy exceeds table size");

  a_place_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PLACE) |-> (occ < lim) && free_found)
    else $error("insertion without a free entry");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid && in_op == OP_CLEAR)
      |=> (occ == '0) && (pending == '0) && (lazy_min == ALL_ONES))
    else $error("clear did not empty the table");

  a_place_drains: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PLACE && from_pend) |=> (pending == '0))
    else $error("pending amount kept after placement");
`endif

endmodule

`default_nettype wire

[rtl/weighted_heavy_hitter_sketch_core.sv]
// ----------------------------------------------------------------------------
// weighted_heavy_hitter_sketch_core
// Weighted frequent-items table with lazy lowering of all counts.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Contents
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | tdata: key[31:0], weight[62:32]; tuser: opcode
//  m_axis   | out       | tdata: key_count, occupancy, min_bound, pending
//  cfg      | in        | slots_in_use, written when cfg_we is high
//
//  An update scans the slots through the key/count memories, with a read
//  state and a compare state per slot. A hit ends the scan at its slot; a
//  scan that finds no hit ends in an insert or in the pending amount.
//  When the pending weight reaches the bound, each lowering pass reads
//  each slot, subtracts on the shared 64-bit adder and updates the minimum
//  for a surviving entry, with at most two passes. A clear empties the
//  table and goes straight to the result.
//  Reset (rst, synchronous) empties the table and sets slots_in_use to 64.
//  A finished result waits in the output register; the next transaction is
//  accepted while it waits, and the sequencer holds only if a second result
//  is ready before the first has been taken.
//
`default_nettype none

module weighted_heavy_hitter_sketch_core
  import whhs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,

  // Input transactions.
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [63:0]  s_axis_tdata,   // key[31:0], weight[62:32], zero[63]
  input  wire logic [0:0]   s_axis_tuser,   // opcode[0]

  // Result transactions.
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [199:0]      m_axis_tdata,   // key_count[63:0], occupancy[70:64],
                                            // min_bound[134:71], pending[198:135],
                                            // zero[199]

  // Configuration register.
  input  wire logic         cfg_we,
  input  wire logic [6:0]   cfg_wdata       // slots_in_use
);

  logic [OCC_W-1:0] slots_in_use;
  logic [OCC_W-1:0] lim;
  logic             out_free;
  logic             res_valid;
  result_t          res;
  tbl_ctrl_t        tc;
  tbl_stat_t        ts;
  opcode_t          in_op;

  // The slot limit register. Zero acts as one slot, and anything above the
  // table size acts as the full table.
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_RST;
    end else if (cfg_we) begin
      slots_in_use <= cfg_wdata;
    end
  end

  always_comb begin
    if (slots_in_use == '0) begin
      lim = OCC_W'(1);
    end else if (slots_in_use > OCC_W'(MAX_SLOTS)) begin
      lim = OCC_W'(MAX_SLOTS);
    end else begin
      lim = slots_in_use;
    end
  end

  assign in_op = opcode_t'(s_axis_tuser[0]);

  whhs_table u_table (
    .clk  (clk),
    .rst  (rst),
    .ctl  (tc),
    .stat (ts)
  );

  whhs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .lim       (lim),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (in_op),
    .in_key    (s_axis_tdata[KEY_W-1:0]),
    .in_weight (s_axis_tdata[KEY_W+WGT_W-1:KEY_W]),
    .res_valid (res_valid),
    .out_free  (out_free),
    .res       (res),
    .tc        (tc),
    .ts        (ts)
  );

  // Output register: it takes a new result whenever it is empty or its
  // current transaction completes in this cycle.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      m_axis_tdata <= {1'b0, res.pending, res.min_bound, res.occupancy, res.key_count};
    end
  end

endmodule

`default_nettype wire

[bench/whhs_bench_pkg.sv]
// ----------------------------------------------------------------------------
// whhs_bench_pkg
// Scoreboard for the weighted heavy-hitter sketch: it mirrors the
// frequent-items table and holds the results that are still due.
// ----------------------------------------------------------------------------

package whhs_bench_pkg;

  import whhs_pkg::*;

  class sketch_scoreboard;

    // Mirror of the table and its bookkeeping.
    bit [KEY_W-1:0] slot_key   [MAX_SLOTS];
    bit [CNT_W-1:0] slot_count [MAX_SLOTS];
    bit             slot_valid [MAX_SLOTS];
    bit [CNT_W-1:0] floor_bound;
    bit [CNT_W-1:0] unplaced;
    int unsigned    occupied;
    bit [OCC_W-1:0] slots_reg;

    result_t        due_results[$];
    int unsigned    mismatches;
    int unsigned    results_seen;

    function new();
      wipe_table();
      slots_reg    = SLOTS_RST;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_slot_limit(bit [OCC_W-1:0] value);
      slots_reg = value;
    endfunction

    function int unsigned outstanding();
      return due_results.size();
    endfunction

    // A register value of zero acts as one, anything above the table size
    // acts as the table size.
    function int unsigned effective_slots();
      if (slots_reg == 0) return 1;
      if (slots_reg > MAX_SLOTS) return MAX_SLOTS;
      return slots_reg;
    endfunction

    function void wipe_table();
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_key[i]   = '0;
        slot_count[i] = '0;
        slot_valid[i] = 1'b0;
      end
      floor_bound = ALL_ONES;
      unplaced    = '0;
      occupied    = 0;
    endfunction

    // Takes amount off every held count, frees what drops to zero or below,
    // and returns the smallest count left (all ones if the table is empty).
    function bit [CNT_W-1:0] lower_counts(bit [CNT_W-1:0] amount);
      bit [CNT_W-1:0] lowest;
      lowest = ALL_ONES;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        if (slot_valid[i]) begin
          if (slot_count[i] <= amount) begin
            slot_valid[i] = 1'b0;
            slot_count[i] = '0;
            occupied--;
          end else begin
            slot_count[i] -= amount;
            if (slot_count[i] < lowest) lowest = slot_count[i];
          end
        end
      end
      return lowest;
    endfunction

    function void claim_slot(bit [KEY_W-1:0] key, bit [CNT_W-1:0] count);
      for (int i = 0; i < MAX_SLOTS; i++) begin
        if (!slot_valid[i]) begin
          slot_valid[i] = 1'b1;
          slot_key[i]   = key;
          slot_count[i] = count;
          occupied++;
          if (count < floor_bound) floor_bound = count;
          return;
        end
      end
    endfunction

    // Returns the count held for key after the update, zero if not held.
    function bit [CNT_W-1:0] tally_update(bit [KEY_W-1:0] key, bit [CNT_W-1:0] weight);
      int unsigned    cap;
      bit [CNT_W-1:0] placed;
      cap = effective_slots();
      for (int i = 0; i < MAX_SLOTS; i++) begin
        if (slot_valid[i] && slot_key[i] == key) begin
          slot_count[i] += weight;
          return slot_count[i];
        end
      end
      if (occupied < cap) begin
        claim_slot(key, weight);
        return weight;
      end
      unplaced += weight;
      if (unplaced < floor_bound) return '0;
      // At most two lowering passes; whatever is left after them stays pending.
      for (int pass = 0; pass < 2; pass++) begin
        unplaced   -= floor_bound;
        floor_bound = lower_counts(floor_bound);
        if (unplaced == 0) return '0;
        if (occupied < cap) begin
          placed   = unplaced;
          claim_slot(key, placed);
          unplaced = '0;
          return placed;
        end
        if (pass == 0 && unplaced < floor_bound) return '0;
      end
      return '0;
    endfunction

    function void note_transaction(opcode_t op, bit [KEY_W-1:0] key, bit [WGT_W-1:0] weight);
      result_t want;
      want.key_count = '0;
      if (op == OP_CLEAR) wipe_table();
      else want.key_count = tally_update(key, CNT_W'(weight));
      want.occupancy = OCC_W'(occupied);
      want.min_bound = floor_bound;
      want.pending   = unplaced;
      due_results.push_back(want);
    endfunction

    function void flag_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at result %0d: %s", results_seen, what);
    endfunction

    function void compare_field(string field, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (got !== want)
        flag_mismatch($sformatf("%s expected %0h, got %0h", field, want, got));
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("result %0h arrived with nothing due", got));
        return;
      end
      want = due_results.pop_front();
      compare_field("key_count", want.key_count, got.key_count);
      compare_field("occupancy", CNT_W'(want.occupancy), CNT_W'(got.occupancy));
      compare_field("min_bound", want.min_bound, got.min_bound);
      compare_field("pending", want.pending, got.pending);
    endfunction

  endclass

endpackage

[bench/weighted_heavy_hitter_sketch_core_test.sv]
// ----------------------------------------------------------------------------
// weighted_heavy_hitter_sketch_core_test
// Self-checking bench for the weighted heavy-hitter sketch core. A short
// directed run covers field extremes, zero weights, clears, lowering passes
// and a table left full after both passes; random phases then sweep the
// slot limit and key mixes while both stream sides idle at random.
// ----------------------------------------------------------------------------

module weighted_heavy_hitter_sketch_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  import whhs_pkg::*;
  import whhs_bench_pkg::*;

  localparam int          CLK_HALF      = 5;
  localparam int          RESET_CYCLES  = 12;
  // The slowest update is a full scan plus two lowering passes, plus idle
  // gaps on each side. The limit allows several times what about 1400 such
  // updates would take.
  localparam int unsigned CYCLE_LIMIT   = 4_000_000;
  // Quiet time after the last result: long enough for a stray extra
  // transaction from a scan and two passes to show up.
  localparam int          SETTLE_CYCLES = 600;

  logic         clk           = 1'b0;
  logic         rst           = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata  = '0;   // key[31:0], weight[62:32], zero[63]
  logic [0:0]   s_axis_tuser  = '0;   // opcode[0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [199:0] m_axis_tdata;         // key_count[63:0], occupancy[70:64],
                                      // min_bound[134:71], pending[198:135], zero[199]
  logic         cfg_we        = 1'b0;
  logic [6:0]   cfg_wdata     = '0;

  int unsigned  cycle_count   = 0;
  int           src_quiet     = 0;
  int           sink_quiet    = 0;

  sketch_scoreboard book = new();

  weighted_heavy_hitter_sketch_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Idle cycles before the next transaction on one side. Now and then a side
  // enters a quiet stretch with no idling at all, so that back-to-back
  // transactions are exercised as well as gaps.
  function automatic int draw_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      quiet_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // Mostly small weights so that pending amounts and counts are comparable
  // and lowering passes happen often; a share of full-range weights keeps
  // every weight bit toggling, and zero and the maximum show up as well.
  function automatic logic [WGT_W-1:0] draw_weight();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return '0;
    if (roll < 5) return '1;
    if (roll < 65) return WGT_W'($urandom_range(1, 64));
    if (roll < 88) return WGT_W'($urandom_range(1, 100000));
    return WGT_W'($urandom);
  endfunction

  // Presents one input transaction and holds it until it is accepted. The
  // valid is only dropped when an idle gap follows, so a back-to-back
  // transaction never sees valid lowered and raised in the same time step.
  task automatic send_item(opcode_t op, logic [KEY_W-1:0] key, logic [WGT_W-1:0] weight);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, weight, key};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    book.note_transaction(op, key, weight);
    gap = draw_gap(src_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Ends a burst of input transactions; must follow the last send_item
  // directly so that the last item is not offered a second time.
  task automatic idle_input();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_results_drained();
    while (book.outstanding() != 0) @(posedge clk);
  endtask

  // The slot limit is only changed while nothing is in flight. Every input
  // transaction yields exactly one result, so once all results are back the
  // core is idle.
  task automatic program_slots(logic [OCC_W-1:0] value);
    wait_results_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    book.set_slot_limit(value);
    cfg_we    <= 1'b0;
  endtask

  // One random phase. Most keys come from a small pool, so that keys recur,
  // counts grow and the table fills; the rest are fresh keys that mostly end
  // up in the pending amount. A few clears are mixed in.
  task automatic run_random_phase(int items, int pool_size);
    logic [KEY_W-1:0] pool[$];
    int unsigned      roll;
    logic [KEY_W-1:0] key;
    for (int i = 0; i < pool_size; i++) pool.push_back($urandom);
    for (int n = 0; n < items; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        send_item(OP_CLEAR, $urandom, WGT_W'($urandom));
      end else begin
        if (roll < 12) key = $urandom;
        else key = pool[$urandom_range(0, pool_size - 1)];
        send_item(OP_UPDATE, key, draw_weight());
      end
    end
    idle_input();
  endtask

  // Result side: takes results with random stalls and hands each one to the
  // scoreboard at the edge where the transaction completes.
  initial begin : result_sink
    int gap;
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap(sink_quiet);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      book.check_result(result_t'(m_axis_tdata[198:0]));
    end
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, slot limit at its reset value of 64. Extreme keys and
    // weights, a hit, and a zero-weight insert that pulls the bound to zero.
    send_item(OP_UPDATE, 32'h0000_0000, 31'd1);
    send_item(OP_UPDATE, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_item(OP_UPDATE, 32'h0000_0000, 31'h7FFF_FFFF);
    send_item(OP_UPDATE, 32'h1234_5678, 31'd0);
    send_item(OP_CLEAR, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    idle_input();

    // Two slots: pending below the bound, a pass that uses up the pending
    // amount exactly, and passes that free entries and place the new key.
    program_slots(7'd2);
    send_item(OP_UPDATE, 32'h0000_0011, 31'd5);
    send_item(OP_UPDATE, 32'h0000_0022, 31'd3);
    send_item(OP_UPDATE, 32'h0000_0033, 31'd2);
    send_item(OP_UPDATE, 32'h0000_0033, 31'd1);
    send_item(OP_UPDATE, 32'h0000_0044, 31'd4);
    send_item(OP_UPDATE, 32'h0000_0055, 31'd10);
    send_item(OP_UPDATE, 32'h0000_0066, 31'd1);
    send_item(OP_UPDATE, 32'h0000_0077, 31'd5);
    send_item(OP_CLEAR, 32'h0000_0000, 31'd0);
    idle_input();

    // Four entries, then the limit is lowered to one, three below the
    // occupancy. The next new key runs both passes and the table is
    // still full afterwards, so the remainder has to stay pending.
    program_slots(7'd4);
    send_item(OP_UPDATE, 32'hA000_0001, 31'd100);
    send_item(OP_UPDATE, 32'hA000_0002, 31'd100);
    send_item(OP_UPDATE, 32'hA000_0003, 31'd300);
    send_item(OP_UPDATE, 32'hA000_0004, 31'd300);
    send_item(OP_UPDATE, 32'hA000_0002, 31'd300);
    idle_input();
    program_slots(7'd1);
    send_item(OP_UPDATE, 32'hA000_0005, 31'd500);
    idle_input();

    // Random phases across the range of the slot limit, including the values
    // that are clamped. Phases do not start with a clear, so a limit below
    // the current occupancy is hit several times along the way.
    program_slots(7'd127);
    run_random_phase(300, 96);
    program_slots(7'd0);
    run_random_phase(150, 4);
    program_slots(7'd8);
    run_random_phase(250, 16);
    program_slots(7'd3);
    run_random_phase(150, 8);
    program_slots(7'd64);
    run_random_phase(200, 80);
    program_slots(7'd16);
    run_random_phase(150, 24);
    program_slots(7'd1);
    run_random_phase(100, 3);
    program_slots(7'd100);
    run_random_phase(100, 70);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.mismatches == 0 && book.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/whhs_pkg.sv
rtl/whhs_alu.sv
rtl/whhs_table.sv
rtl/whhs_ctrl.sv
rtl/weighted_heavy_hitter_sketch_core.sv
bench/whhs_bench_pkg.sv
bench/weighted_heavy_hitter_sketch_core_test.sv
